### sv/lpg_pkg.sv
// Shared constants, types and the command format for the line point generator.
package lpg_pkg;

   localparam int COORD_BITS = 12;
   localparam int DELTA_BITS = COORD_BITS + 1;
   localparam int ERR_BITS   = COORD_BITS + 3;
   localparam int E2_BITS    = ERR_BITS + 1;
   localparam int COLOR_BITS = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [0:0] {
      OP_LOAD = 1'b0,
      OP_EMIT = 1'b1
   } op_type;

   typedef struct packed {
      op_type                         op;
      logic signed [COORD_BITS-1:0]   cur_x;
      logic signed [COORD_BITS-1:0]   cur_y;
      logic signed [COORD_BITS-1:0]   target_x;
      logic signed [COORD_BITS-1:0]   target_y;
      logic signed [DELTA_BITS-1:0]   delta_x;
      logic signed [DELTA_BITS-1:0]   neg_delta_y;
      logic                           step_x_neg;
      logic                           step_y_neg;
      logic signed [ERR_BITS-1:0]     error_init;
      logic        [COLOR_BITS-1:0]   color;
   } cmd_type;

endpackage

### sv/lpg_front.sv
// Input side: accepts items, decodes the operation and precomputes line setup.
module lpg_front (
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_operation,
   input  logic signed [lpg_pkg::COORD_BITS-1:0] req_x_start,
   input  logic signed [lpg_pkg::COORD_BITS-1:0] req_y_start,
   input  logic signed [lpg_pkg::COORD_BITS-1:0] req_x_end,
   input  logic signed [lpg_pkg::COORD_BITS-1:0] req_y_end,
   input  logic        [lpg_pkg::COLOR_BITS-1:0] req_line_color,
   input  logic                                 queue_full,
   output logic                                 queue_push,
   output lpg_pkg::cmd_type                     queue_cmd
);
   import lpg_pkg::*;

   logic signed [DELTA_BITS-1:0] x0_ext, y0_ext, x1_ext, y1_ext;
   logic signed [DELTA_BITS-1:0] dx, ndy;

   assign req_ready  = !queue_full;
   assign queue_push = req_valid && !queue_full;

   always_comb begin
      x0_ext = DELTA_BITS'(req_x_start);
      y0_ext = DELTA_BITS'(req_y_start);
      x1_ext = DELTA_BITS'(req_x_end);
      y1_ext = DELTA_BITS'(req_y_end);
      dx  = (x1_ext > x0_ext) ? (x1_ext - x0_ext) : (x0_ext - x1_ext);
      // The y span is kept negated, as the error update uses it that way.
      ndy = (y1_ext > y0_ext) ? (y0_ext - y1_ext) : (y1_ext - y0_ext);

      queue_cmd.op          = op_type'(req_operation);
      queue_cmd.cur_x       = req_x_start;
      queue_cmd.cur_y       = req_y_start;
      queue_cmd.target_x    = req_x_end;
      queue_cmd.target_y    = req_y_end;
      queue_cmd.delta_x     = dx;
      queue_cmd.neg_delta_y = ndy;
      queue_cmd.step_x_neg  = !(req_x_start < req_x_end);
      queue_cmd.step_y_neg  = !(req_y_start < req_y_end);
      queue_cmd.error_init  = ERR_BITS'(dx) + ERR_BITS'(ndy);
      queue_cmd.color       = req_line_color;
   end

endmodule

### sv/lpg_queue.sv
// Small command queue between the input side and the point stepper.
module lpg_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lpg_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output lpg_pkg::cmd_type pop_cmd
);
   import lpg_pkg::*;

   cmd_type               entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   logic                  do_push, do_pop;

   assign full    = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_BITS'(do_push) - QCNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### sv/lpg_back.sv
// Point stepper: holds the line state, runs at most one Bresenham step per emit item.
module lpg_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  queue_empty,
   input  lpg_pkg::cmd_type                      queue_cmd,
   output logic                                  queue_pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [lpg_pkg::COORD_BITS-1:0] rsp_point_x,
   output logic signed [lpg_pkg::COORD_BITS-1:0] rsp_point_y,
   output logic        [lpg_pkg::COLOR_BITS-1:0] rsp_point_color,
   output logic                                  rsp_point_valid,
   output logic                                  rsp_point_last
);
   import lpg_pkg::*;

   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [COORD_BITS-1:0] target_x_ff, target_x_in, target_y_ff, target_y_in;
   logic signed [DELTA_BITS-1:0] delta_x_ff, delta_x_in, neg_delta_y_ff, neg_delta_y_in;
   logic                         step_x_neg_ff, step_x_neg_in, step_y_neg_ff, step_y_neg_in;
   logic signed [ERR_BITS-1:0]   error_ff, error_in;
   logic        [COLOR_BITS-1:0] color_ff, color_in;
   logic                         busy_ff, busy_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_BITS-1:0] pt_x_ff, pt_x_in, pt_y_ff, pt_y_in;
   logic        [COLOR_BITS-1:0] pt_color_ff, pt_color_in;
   logic                         pt_valid_ff, pt_valid_in, pt_last_ff, pt_last_in;

   logic                         advance, at_end, move_x, move_y;
   logic signed [E2_BITS-1:0]    e2;
   logic signed [ERR_BITS-1:0]   error_step;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign queue_pop = advance && !queue_empty;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_x     = pt_x_ff;
   assign rsp_point_y     = pt_y_ff;
   assign rsp_point_color = pt_color_ff;
   assign rsp_point_valid = pt_valid_ff;
   assign rsp_point_last  = pt_last_ff;

   always_comb begin
      at_end = (cur_x_ff == target_x_ff) && (cur_y_ff == target_y_ff);
      e2     = {error_ff, 1'b0};
      move_x = (e2 >= E2_BITS'(neg_delta_y_ff));
      move_y = (e2 <= E2_BITS'(delta_x_ff));
      error_step = error_ff
                 + (move_x ? ERR_BITS'(neg_delta_y_ff) : ERR_BITS'(0))
                 + (move_y ? ERR_BITS'(delta_x_ff) : ERR_BITS'(0));
   end

   always_comb begin
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      target_x_in    = target_x_ff;
      target_y_in    = target_y_ff;
      delta_x_in     = delta_x_ff;
      neg_delta_y_in = neg_delta_y_ff;
      step_x_neg_in  = step_x_neg_ff;
      step_y_neg_in  = step_y_neg_ff;
      error_in       = error_ff;
      color_in       = color_ff;
      busy_in        = busy_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pt_x_in      = pt_x_ff;
      pt_y_in      = pt_y_ff;
      pt_color_in  = pt_color_ff;
      pt_valid_in  = pt_valid_ff;
      pt_last_in   = pt_last_ff;

      if (queue_pop) begin
         // Loads and idle emits still return an item, with every field zero.
         rsp_valid_in = 1'b1;
         pt_x_in      = '0;
         pt_y_in      = '0;
         pt_color_in  = '0;
         pt_valid_in  = 1'b0;
         pt_last_in   = 1'b0;
         unique case (queue_cmd.op)
            OP_LOAD: begin
               cur_x_in       = queue_cmd.cur_x;
               cur_y_in       = queue_cmd.cur_y;
               target_x_in    = queue_cmd.target_x;
               target_y_in    = queue_cmd.target_y;
               delta_x_in     = queue_cmd.delta_x;
               neg_delta_y_in = queue_cmd.neg_delta_y;
               step_x_neg_in  = queue_cmd.step_x_neg;
               step_y_neg_in  = queue_cmd.step_y_neg;
               error_in       = queue_cmd.error_init;
               color_in       = queue_cmd.color;
               busy_in        = 1'b1;
            end
            OP_EMIT: begin
               if (busy_ff) begin
                  pt_x_in     = cur_x_ff;
                  pt_y_in     = cur_y_ff;
                  pt_color_in = color_ff;
                  pt_valid_in = 1'b1;
                  if (at_end) begin
                     pt_last_in = 1'b1;
                     busy_in    = 1'b0;
                  end else begin
                     error_in = error_step;
                     if (move_x) begin
                        cur_x_in = step_x_neg_ff ? cur_x_ff - COORD_BITS'(1)
                                                 : cur_x_ff + COORD_BITS'(1);
                     end
                     if (move_y) begin
                        cur_y_in = step_y_neg_ff ? cur_y_ff - COORD_BITS'(1)
                                                 : cur_y_ff + COORD_BITS'(1);
                     end
                  end
               end
            end
            default: begin
               busy_in = busy_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff       <= cur_x_in;
      cur_y_ff       <= cur_y_in;
      target_x_ff    <= target_x_in;
      target_y_ff    <= target_y_in;
      delta_x_ff     <= delta_x_in;
      neg_delta_y_ff <= neg_delta_y_in;
      step_x_neg_ff  <= step_x_neg_in;
      step_y_neg_ff  <= step_y_neg_in;
      error_ff       <= error_in;
      color_ff       <= color_in;
      pt_x_ff        <= pt_x_in;
      pt_y_ff        <= pt_y_in;
      pt_color_ff    <= pt_color_in;
      pt_valid_ff    <= pt_valid_in;
      pt_last_ff     <= pt_last_in;
   end

   a_last_has_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!pt_last_ff || pt_valid_ff))
      else $error("endpoint flagged on an item without a point");

   a_end_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (queue_pop && queue_cmd.op == OP_EMIT && busy_ff && at_end) |=>
         (!busy_ff && rsp_valid_ff && pt_last_ff))
      else $error("line endpoint did not return the stepper to idle");

   a_load_arms: assert property (@(posedge clock) disable iff (reset)
      (queue_pop && queue_cmd.op == OP_LOAD) |=>
         (busy_ff && rsp_valid_ff && !pt_valid_ff))
      else $error("load did not arm the stepper with a blank item");

   a_idle_emit_blank: assert property (@(posedge clock) disable iff (reset)
      (queue_pop && queue_cmd.op == OP_EMIT && !busy_ff) |=>
         (rsp_valid_ff && !pt_valid_ff && !pt_last_ff))
      else $error("emit while idle produced a point");

endmodule

### sv/line_point_generator.sv
// Top level of the Bresenham line point generator: front end, queue and stepper.
// An accepted item is written into the queue, then popped into the stepper's output register.
// Throughput: one item per cycle while rsp_ready does not hold the stepper's output register.
// The four-entry queue lets input accepts continue while results wait on rsp_ready.
// Reset is synchronous and clears the queue, the output valid and the busy flag to idle.
module line_point_generator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_operation,
   input  logic signed [lpg_pkg::COORD_BITS-1:0] req_x_start,
   input  logic signed [lpg_pkg::COORD_BITS-1:0] req_y_start,
   input  logic signed [lpg_pkg::COORD_BITS-1:0] req_x_end,
   input  logic signed [lpg_pkg::COORD_BITS-1:0] req_y_end,
   input  logic        [lpg_pkg::COLOR_BITS-1:0] req_line_color,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [lpg_pkg::COORD_BITS-1:0] rsp_point_x,
   output logic signed [lpg_pkg::COORD_BITS-1:0] rsp_point_y,
   output logic        [lpg_pkg::COLOR_BITS-1:0] rsp_point_color,
   output logic                                  rsp_point_valid,
   output logic                                  rsp_point_last
);
   import lpg_pkg::*;

   cmd_type push_cmd, pop_cmd;
   logic    push, pop, full, empty;

   lpg_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_x_start    (req_x_start),
      .req_y_start    (req_y_start),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .req_line_color (req_line_color),
      .queue_full     (full),
      .queue_push     (push),
      .queue_cmd      (push_cmd)
   );

   lpg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .empty    (empty),
      .pop_cmd  (pop_cmd)
   );

   lpg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (empty),
      .queue_cmd       (pop_cmd),
      .queue_pop       (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_point_color (rsp_point_color),
      .rsp_point_valid (rsp_point_valid),
      .rsp_point_last  (rsp_point_last)
   );

endmodule

### test/tb_line_point_generator.sv
// Self-checking testbench for the line point generator: directed and random lines.
`timescale 1ns / 1ps

module tb_line_point_generator;
   import lpg_pkg::*;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DELTA_BITS-1:0] delta_type;
   typedef logic signed [ERR_BITS-1:0]   err_type;
   typedef logic signed [E2_BITS-1:0]    e2_type;
   typedef logic        [COLOR_BITS-1:0] color_type;

   typedef struct {
      coord_type x;
      coord_type y;
      color_type color;
      logic      valid;
      logic      last;
   } point_type;

   localparam int COORD_MIN = -(1 << (COORD_BITS - 1));
   localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;

   logic      clock;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   op_type    req_operation = OP_LOAD;
   coord_type req_x_start = '0;
   coord_type req_y_start = '0;
   coord_type req_x_end = '0;
   coord_type req_y_end = '0;
   color_type req_line_color = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   coord_type rsp_point_x;
   coord_type rsp_point_y;
   color_type rsp_point_color;
   logic      rsp_point_valid;
   logic      rsp_point_last;

   line_point_generator DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_x_end       (req_x_end),
      .req_y_end       (req_y_end),
      .req_line_color  (req_line_color),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_point_color (rsp_point_color),
      .rsp_point_valid (rsp_point_valid),
      .rsp_point_last  (rsp_point_last)
   );

   // Rasterizer state as the generator should hold it.
   coord_type pos_x = '0;
   coord_type pos_y = '0;
   coord_type goal_x = '0;
   coord_type goal_y = '0;
   delta_type span_x = '0;
   delta_type neg_span_y = '0;
   logic      dir_x_neg = 1'b0;
   logic      dir_y_neg = 1'b0;
   err_type   err_acc = '0;
   color_type held_color = '0;
   logic      drawing = 1'b0;

   point_type expected_points[$];
   int        mismatches = 0;
   int        items_sent = 0;
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Works out the point the generator reports for one item and advances the line.
   function automatic void predict_point(input op_type op,
                                         input coord_type x0, input coord_type y0,
                                         input coord_type x1, input coord_type y1,
                                         input color_type color);
      point_type p;
      e2_type    twice_err;
      p = '{x: '0, y: '0, color: '0, valid: 1'b0, last: 1'b0};
      if (op == OP_LOAD) begin
         pos_x      = x0;
         pos_y      = y0;
         goal_x     = x1;
         goal_y     = y1;
         span_x     = (x1 > x0) ? delta_type'(x1) - delta_type'(x0)
                                : delta_type'(x0) - delta_type'(x1);
         neg_span_y = (y1 > y0) ? delta_type'(y0) - delta_type'(y1)
                                : delta_type'(y1) - delta_type'(y0);
         dir_x_neg  = !(x0 < x1);
         dir_y_neg  = !(y0 < y1);
         err_acc    = err_type'(span_x) + err_type'(neg_span_y);
         held_color = color;
         drawing    = 1'b1;
      end else if (drawing) begin
         p.x     = pos_x;
         p.y     = pos_y;
         p.color = held_color;
         p.valid = 1'b1;
         if (pos_x == goal_x && pos_y == goal_y) begin
            p.last  = 1'b1;
            drawing = 1'b0;
         end else begin
            // Both tests use the error value from before this step.
            twice_err = e2_type'(err_acc) + e2_type'(err_acc);
            if (twice_err >= neg_span_y) begin
               err_acc = err_acc + err_type'(neg_span_y);
               pos_x   = dir_x_neg ? pos_x - coord_type'(1) : pos_x + coord_type'(1);
            end
            if (twice_err <= span_x) begin
               err_acc = err_acc + err_type'(span_x);
               pos_y   = dir_y_neg ? pos_y - coord_type'(1) : pos_y + coord_type'(1);
            end
         end
      end
      expected_points.push_back(p);
   endfunction

   function automatic int rand_coord();
      return int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
   endfunction

   // A coordinate within span of c, kept inside the field's range.
   function automatic int near_coord(input int c, input int span);
      int v;
      v = c + int'($urandom_range(2 * span)) - span;
      if (v < COORD_MIN) v = COORD_MIN;
      if (v > COORD_MAX) v = COORD_MAX;
      return v;
   endfunction

   task automatic send_item(input op_type op, input coord_type x0, input coord_type y0,
                            input coord_type x1, input coord_type y1,
                            input color_type color);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      predict_point(op, x0, y0, x1, y1, color);
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_x_start    <= x0;
      req_y_start    <= y0;
      req_x_end      <= x1;
      req_y_end      <= y1;
      req_line_color <= color;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Emit items carry random payload, which the generator must ignore.
   task automatic send_emit();
      send_item(OP_EMIT, coord_type'(rand_coord()), coord_type'(rand_coord()),
                coord_type'(rand_coord()), coord_type'(rand_coord()), $urandom());
   endtask

   // Loads a line and steps it, stopping at the endpoint or after max_emits items.
   task automatic draw_line(input int x0, input int y0, input int x1, input int y1,
                            input color_type color, input int max_emits);
      int n;
      n = ((x1 > x0 ? x1 - x0 : x0 - x1) > (y1 > y0 ? y1 - y0 : y0 - y1)) ?
          (x1 > x0 ? x1 - x0 : x0 - x1) + 1 : (y1 > y0 ? y1 - y0 : y0 - y1) + 1;
      if (n > max_emits) n = max_emits;
      send_item(OP_LOAD, coord_type'(x0), coord_type'(y0), coord_type'(x1),
                coord_type'(y1), color);
      repeat (n) send_emit();
   endtask

   task automatic wait_all_points();
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   task automatic test_directed_cases();
      // Step while idle after reset.
      send_emit();
      // Full-range diagonal, abandoned by a load of a single-point line.
      draw_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 32'hFFFF_FFFF, 3);
      draw_line(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 32'h0000_0000, 1);
      // Step after the endpoint has been reported.
      send_emit();
      // Horizontal line running toward smaller x.
      draw_line(5, 3, 2, 3, 32'hA5A5_A5A5, 4);
      // Vertical line running toward larger y.
      draw_line(-7, 0, -7, 2, 32'h5A5A_5A5A, 3);
      // Steep line ending at the largest coordinates.
      draw_line(COORD_MAX - 2, COORD_MAX - 3, COORD_MAX, COORD_MAX, 32'h8000_0001, 4);
   endtask

   task automatic test_random_lines(input int count);
      int stop_at;
      int pick;
      int span;
      int x1;
      int y1;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         span = ($urandom_range(9) == 0) ? 200 : 15;
         x1   = rand_coord();
         y1   = rand_coord();
         if (pick < 70) begin
            draw_line(near_coord(x1, span), near_coord(y1, span), x1, y1, $urandom(), 1 << 30);
         end else if (pick < 80) begin
            // Long line, cut short by the next load.
            draw_line(rand_coord(), rand_coord(), x1, y1, $urandom(), $urandom_range(1, 20));
         end else if (pick < 90) begin
            draw_line(near_coord(x1, span), near_coord(y1, span), x1, y1, $urandom(),
                      $urandom_range(0, 4));
         end else begin
            repeat ($urandom_range(1, 3))
               send_item(op_type'($urandom_range(1)), coord_type'(rand_coord()),
                         coord_type'(rand_coord()), coord_type'(rand_coord()),
                         coord_type'(rand_coord()), $urandom());
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : check_points
      point_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected point x=%0d y=%0d color=%h valid=%b last=%b",
                        rsp_point_x, rsp_point_y, rsp_point_color, rsp_point_valid,
                        rsp_point_last);
         end else begin
            want = expected_points.pop_front();
            if (rsp_point_x !== want.x || rsp_point_y !== want.y ||
                rsp_point_color !== want.color || rsp_point_valid !== want.valid ||
                rsp_point_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t: got x=%0d y=%0d color=%h valid=%b last=%b, %s",
                           $realtime, rsp_point_x, rsp_point_y, rsp_point_color,
                           rsp_point_valid, rsp_point_last,
                           $sformatf("expected x=%0d y=%0d color=%h valid=%b last=%b",
                                     want.x, want.y, want.color, want.valid, want.last));
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_idling(16, 66);
      test_directed_cases();
      test_random_lines(270);
      wait_all_points();
      set_idling(66, 16);
      test_random_lines(270);
      wait_all_points();
      set_idling(0, 0);
      test_random_lines(270);
      wait_all_points();
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

### sim.f
sv/lpg_pkg.sv
sv/lpg_front.sv
sv/lpg_queue.sv
sv/lpg_back.sv
sv/line_point_generator.sv
test/tb_line_point_generator.sv
